[sv/ssfp_pkg.sv]
// ----------------------------------------------------------------------------
// ssfp_pkg
// Shared constants for the SPI slave frame parser: frame length, header and
// command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package ssfp_pkg;

	// Command frame length in bytes (2..16)
	localparam int FRAME_BYTES = 8;
	localparam int CNT_W       = $clog2(FRAME_BYTES);
	// Frame position of the last byte as carried on the 3-bit index field
	localparam logic [2:0] LAST_INDEX = 3'((FRAME_BYTES - 1) % 8);

	// Feedback table geometry
	localparam int TABLE_BYTES = 8;
	localparam int FB_IDX_W    = 4;

	// Byte codes
	localparam logic [7:0] HDR_FRAME      = 8'hA5;
	localparam logic [7:0] HDR_FB_FIRST   = 8'hF5;
	localparam logic [7:0] HDR_FB_SECOND  = 8'h5F;
	localparam logic [7:0] CMD_FB_RESTART = 8'h55;
	localparam logic [7:0] CMD_FB_SEND    = 8'hAA;

	// Configuration register indexes
	localparam logic [1:0] REG_DATA_WORD = 2'd0;
	localparam logic [1:0] REG_RATE_WORD = 2'd1;
	localparam logic [1:0] REG_SELECT    = 2'd2;

	// Register reset values
	localparam logic [63:0] RESET_DATA_WORD = 64'h100E0C0A08060402;
	localparam logic [63:0] RESET_RATE_WORD = 64'h0;

endpackage

[sv/spi_slave_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// spi_slave_frame_parser_unit
// Parses received SPI bytes: captures command frames opened by 0xA5 and
// serves feedback bytes from a configurable table once feedback is armed.
// ----------------------------------------------------------------------------
// One result word per received byte, one byte per cycle while the result side
// does not stall. The parser state and the result register update on the same
// edge the byte is accepted, so the result is valid in the next cycle. The
// result register decouples the sides: a new byte is taken whenever the result
// register is empty or its word is taken in the same cycle. Configuration writes
// are always accepted and take effect on the next byte; write only while idle.
module spi_slave_frame_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	// received byte channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        capture_valid,
	output logic [2:0]  capture_index,
	output logic [7:0]  capture_byte,
	output logic        frame_done,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	// Configuration registers
	logic [63:0] data_word_q;
	logic [63:0] rate_word_q;
	logic        select_q;

	// Parser state
	logic                        capturing_q;
	logic [ssfp_pkg::CNT_W-1:0]  count_q;
	logic                        awaiting_q;
	logic                        armed_q;
	logic [ssfp_pkg::FB_IDX_W-1:0] fb_idx_q;

	logic accept;

	// Next-state and result logic
	logic                          cap_mid;
	logic [ssfp_pkg::CNT_W-1:0]    count_mid;
	logic                          cap_last;
	logic                          await_mid;
	logic                          armed_mid;
	logic                          is_restart;
	logic                          is_send;
	logic [ssfp_pkg::FB_IDX_W-1:0] idx_mid;
	logic [63:0]                   table_word;
	logic [7:0]                    table_byte;
	logic                          idx_in_table;

	logic                          capturing_d;
	logic [ssfp_pkg::CNT_W-1:0]    count_d;
	logic                          awaiting_d;
	logic                          armed_d;
	logic [ssfp_pkg::FB_IDX_W-1:0] fb_idx_d;

	logic       res_cap_valid;
	logic [2:0] res_cap_index;
	logic [7:0] res_cap_byte;
	logic       res_done;
	logic       res_tx_valid;
	logic [7:0] res_tx_byte;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid || out_ready;
	assign accept    = in_valid && in_ready;

	// Command capture: open a frame on the header byte when idle
	always_comb begin
		cap_mid   = capturing_q || (rx_byte == ssfp_pkg::HDR_FRAME);
		count_mid = capturing_q ? count_q : '0;
		cap_last  = (count_mid == ssfp_pkg::CNT_W'(ssfp_pkg::FRAME_BYTES - 1));

		res_cap_valid = cap_mid;
		res_cap_index = cap_mid ? 3'(count_mid) : 3'd0;
		res_cap_byte  = cap_mid ? rx_byte : 8'd0;
		res_done      = cap_mid && cap_last;

		capturing_d = cap_mid && !cap_last;
		count_d     = (cap_mid && !cap_last) ? count_mid + 1'b1 : '0;
	end

	// Feedback arming and transmit
	always_comb begin
		await_mid = awaiting_q || (rx_byte == ssfp_pkg::HDR_FB_FIRST);
		armed_mid = armed_q || (await_mid && rx_byte == ssfp_pkg::HDR_FB_SECOND);
		awaiting_d = await_mid && (rx_byte != ssfp_pkg::HDR_FB_SECOND);

		is_restart = (rx_byte == ssfp_pkg::CMD_FB_RESTART);
		is_send    = (rx_byte == ssfp_pkg::CMD_FB_SEND);
		idx_mid    = is_restart ? '0 : fb_idx_q;
		idx_in_table = (idx_mid < ssfp_pkg::FB_IDX_W'(ssfp_pkg::TABLE_BYTES));

		// pick table, then byte; past the table reads zero
		table_word = select_q ? rate_word_q : data_word_q;
		table_byte = idx_in_table ? table_word[{idx_mid[2:0], 3'b000} +: 8] : 8'd0;

		res_tx_valid = armed_mid && (is_restart || is_send);
		res_tx_byte  = res_tx_valid ? table_byte : 8'd0;

		// step the index after every armed byte, disarm past the table
		armed_d  = armed_mid;
		fb_idx_d = fb_idx_q;
		if (armed_mid) begin
			if (idx_in_table) begin
				fb_idx_d = idx_mid + 1'b1;
			end else begin
				fb_idx_d = '0;
				armed_d  = 1'b0;
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_word_q <= ssfp_pkg::RESET_DATA_WORD;
			rate_word_q <= ssfp_pkg::RESET_RATE_WORD;
			select_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ssfp_pkg::REG_DATA_WORD: data_word_q <= cfg_data;
				ssfp_pkg::REG_RATE_WORD: rate_word_q <= cfg_data;
				ssfp_pkg::REG_SELECT:    select_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Parser state: advance on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capturing_q <= 1'b0;
			count_q     <= '0;
			awaiting_q  <= 1'b0;
			armed_q     <= 1'b0;
			fb_idx_q    <= '0;
		end else if (accept) begin
			capturing_q <= capturing_d;
			count_q     <= count_d;
			awaiting_q  <= awaiting_d;
			armed_q     <= armed_d;
			fb_idx_q    <= fb_idx_d;
		end
	end

	// Result register valid: set on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Result payload: load on accept, hold otherwise
	always_ff @(posedge clk) begin
		if (accept) begin
			capture_valid <= res_cap_valid;
			capture_index <= res_cap_index;
			capture_byte  <= res_cap_byte;
			frame_done    <= res_done;
			tx_valid      <= res_tx_valid;
			tx_byte       <= res_tx_byte;
		end
	end

endmodule

[sv/ssfp_checker.sv]
// ----------------------------------------------------------------------------
// ssfp_checker
// Port-level checks for the SPI slave frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module ssfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       capture_valid,
	input logic [2:0] capture_index,
	input logic [7:0] capture_byte,
	input logic       frame_done,
	input logic       tx_valid,
	input logic [7:0] tx_byte
);

	// An accepted byte shows a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted byte produced no result word");

	// Capture fields are zero outside a frame
	a_capture_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !capture_valid |->
			capture_index == 3'd0 && capture_byte == 8'd0 && !frame_done)
		else $error("capture fields set outside a frame");

	// Frame done only on the last captured position
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |->
			capture_valid && capture_index == ssfp_pkg::LAST_INDEX)
		else $error("frame done on a byte that is not the last of a frame");

	// No feedback byte without a transmit load
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_byte == 8'd0)
		else $error("tx byte set without tx valid");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(capture_valid) && $stable(capture_index)
			&& $stable(capture_byte) && $stable(frame_done)
			&& $stable(tx_valid) && $stable(tx_byte))
		else $error("stalled result word changed");

endmodule

bind spi_slave_frame_parser_unit ssfp_checker u_ssfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.capture_valid (capture_valid),
	.capture_index (capture_index),
	.capture_byte  (capture_byte),
	.frame_done    (frame_done),
	.tx_valid      (tx_valid),
	.tx_byte       (tx_byte)
);
